>>> hdl/assert_macros.svh
// Assertion macros for the scanline unfilter RTL.
// Used by the top level; clk and rst_n are taken from the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPL(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> hdl/psu_pkg.sv
// Shared types and constants for the scanline unfilter.
// No dependencies; imported by control, reconstruction, top and testbench.
package psu_pkg;

    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } filt_t;

    localparam logic [7:0] FILT_MAX_CODE = 8'd4;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_BPP       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_BYTES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 2'd2;

    localparam int BPP_W   = 4;
    localparam int RB_W    = 15;
    localparam int RC_W    = 16;
    localparam int CNT_W   = 17;

    typedef struct packed {
        logic       bad;
        logic       first_row;
        filt_t      filter;
        logic       row_last;
        logic       image_last;
        logic [7:0] data;
    } item_t;

endpackage

>>> hdl/psu_ram.sv
// Generic simple dual-port RAM with registered read and read enable.
// No dependencies.
module psu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/psu_ctrl.sv
// Row sequencer: filter byte decode, column/row counting, line buffer read issue.
// Depends on psu_pkg; feeds the reconstruction stage.
module psu_ctrl #(
    parameter int MAX_ROW_BYTES   = 16384,
    parameter int MAX_PIXEL_BYTES = 8,
    parameter int AW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1,
    parameter int SW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [psu_pkg::BPP_W-1:0]  cfg_bpp,
    input  logic [psu_pkg::RB_W-1:0]   cfg_row_bytes,
    input  logic [psu_pkg::RC_W-1:0]   cfg_row_count,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [7:0]                 in_byte,
    input  logic                       in_start,
    input  logic                       take,
    output logic                       item_valid,
    output psu_pkg::item_t             item,
    output logic [AW-1:0]              item_addr,
    output logic [SW-1:0]              item_slot,
    output logic                       hist_clear,
    output logic                       rd_en,
    output logic [AW-1:0]              rd_addr
);
    import psu_pkg::*;

    localparam logic [CNT_W-1:0] MAX_RB = CNT_W'(MAX_ROW_BYTES);
    localparam logic [BPP_W-1:0] MAX_PB = BPP_W'(MAX_PIXEL_BYTES);

    logic            expect_reg, expect_next;
    logic [AW-1:0]   pos_reg, pos_next;
    logic [2:0]      m8_reg, m8_next;
    logic [1:0]      m3_reg, m3_next;
    logic [2:0]      m5_reg, m5_next;
    logic [2:0]      m7_reg, m7_next;
    filt_t           filter_reg, filter_next;
    logic [RC_W-1:0] row_index_reg, row_index_next;
    logic            first_reg, first_next;
    logic            drop_reg, drop_next;

    logic            s1_valid_reg, s1_valid_next;
    item_t           s1_item_reg, s1_item_next;
    logic [AW-1:0]   s1_addr_reg;
    logic [SW-1:0]   s1_slot_reg;

    logic             accept;
    logic             eff_drop, eff_expect, eff_first;
    logic [RC_W-1:0]  eff_row_index;
    logic [CNT_W-1:0] eff_rb, eff_rc, pos_plus, row_plus;
    logic [BPP_W-1:0] eff_bpp;
    logic [2:0]       m6, slot_full;
    logic [SW-1:0]    slot;
    logic             rlast, ilast, is_data;

    assign in_ready = !s1_valid_reg || take;
    assign accept   = in_valid && in_ready;

    assign eff_drop      = !in_start && drop_reg;
    assign eff_expect    = in_start || expect_reg;
    assign eff_first     = in_start || first_reg;
    assign eff_row_index = in_start ? '0 : row_index_reg;

    assign eff_rb = (cfg_row_bytes == '0) ? CNT_W'(1) :
                    ((CNT_W'(cfg_row_bytes) > MAX_RB) ? MAX_RB : CNT_W'(cfg_row_bytes));
    assign eff_rc = (cfg_row_count == '0) ? CNT_W'(1) : CNT_W'(cfg_row_count);
    assign eff_bpp = (cfg_bpp == '0) ? BPP_W'(1) :
                     ((cfg_bpp > MAX_PB) ? MAX_PB : cfg_bpp);

    assign pos_plus  = CNT_W'(pos_reg) + CNT_W'(1);
    assign row_plus  = CNT_W'(row_index_reg) + CNT_W'(1);
    assign rlast     = pos_plus >= eff_rb;
    assign ilast     = row_plus >= eff_rc;

    // column modulo six from its residues modulo two and three
    assign m6 = (m3_reg[0] == m8_reg[0]) ? {1'b0, m3_reg} : ({1'b0, m3_reg} + 3'd3);

    always_comb
    begin
        unique case (eff_bpp)
            4'd1:    slot_full = 3'd0;
            4'd2:    slot_full = {2'b00, m8_reg[0]};
            4'd3:    slot_full = {1'b0, m3_reg};
            4'd4:    slot_full = {1'b0, m8_reg[1:0]};
            4'd5:    slot_full = m5_reg;
            4'd6:    slot_full = m6;
            4'd7:    slot_full = m7_reg;
            4'd8:    slot_full = m8_reg;
            default: slot_full = 3'd0;
        endcase
    end

    assign slot = slot_full[SW-1:0];

    assign is_data    = !eff_drop && !eff_expect;
    assign hist_clear = accept && !eff_drop && eff_expect;
    assign rd_en      = accept && is_data;
    assign rd_addr    = pos_reg;

    always_comb
    begin
        expect_next    = expect_reg;
        pos_next       = pos_reg;
        m8_next        = m8_reg;
        m3_next        = m3_reg;
        m5_next        = m5_reg;
        m7_next        = m7_reg;
        filter_next    = filter_reg;
        row_index_next = row_index_reg;
        first_next     = first_reg;
        drop_next      = drop_reg;
        s1_valid_next  = s1_valid_reg && !take;
        s1_item_next   = s1_item_reg;

        if (accept && !eff_drop)
        begin
            if (eff_expect)
            begin
                first_next     = eff_first;
                row_index_next = eff_row_index;
                expect_next    = 1'b1;
                if (in_byte > FILT_MAX_CODE)
                begin
                    drop_next              = 1'b1;
                    s1_valid_next          = 1'b1;
                    s1_item_next           = '0;
                    s1_item_next.bad       = 1'b1;
                    s1_item_next.data      = in_byte;
                end
                else
                begin
                    drop_next   = 1'b0;
                    expect_next = 1'b0;
                    filter_next = filt_t'(in_byte[2:0]);
                    pos_next    = '0;
                    m8_next     = '0;
                    m3_next     = '0;
                    m5_next     = '0;
                    m7_next     = '0;
                end
            end
            else
            begin
                s1_valid_next           = 1'b1;
                s1_item_next.bad        = 1'b0;
                s1_item_next.first_row  = first_reg;
                s1_item_next.filter     = filter_reg;
                s1_item_next.row_last   = rlast;
                s1_item_next.image_last = rlast && ilast;
                s1_item_next.data       = in_byte;
                if (rlast)
                begin
                    expect_next    = 1'b1;
                    first_next     = 1'b0;
                    row_index_next = row_plus[RC_W-1:0];
                    drop_next      = ilast;
                end
                else
                begin
                    pos_next = pos_plus[AW-1:0];
                    m8_next  = m8_reg + 3'd1;
                    m3_next  = (m3_reg == 2'd2) ? 2'd0 : (m3_reg + 2'd1);
                    m5_next  = (m5_reg == 3'd4) ? 3'd0 : (m5_reg + 3'd1);
                    m7_next  = (m7_reg == 3'd6) ? 3'd0 : (m7_reg + 3'd1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_reg    <= 1'b1;
            pos_reg       <= '0;
            m8_reg        <= '0;
            m3_reg        <= '0;
            m5_reg        <= '0;
            m7_reg        <= '0;
            filter_reg    <= FILT_NONE;
            row_index_reg <= '0;
            first_reg     <= 1'b1;
            drop_reg      <= 1'b0;
            s1_valid_reg  <= 1'b0;
        end
        else
        begin
            expect_reg    <= expect_next;
            pos_reg       <= pos_next;
            m8_reg        <= m8_next;
            m3_reg        <= m3_next;
            m5_reg        <= m5_next;
            m7_reg        <= m7_next;
            filter_reg    <= filter_next;
            row_index_reg <= row_index_next;
            first_reg     <= first_next;
            drop_reg      <= drop_next;
            s1_valid_reg  <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_item_reg <= s1_item_next;
        if (rd_en)
        begin
            s1_addr_reg <= pos_reg;
            s1_slot_reg <= slot;
        end
    end

    assign item_valid = s1_valid_reg;
    assign item       = s1_item_reg;
    assign item_addr  = s1_addr_reg;
    assign item_slot  = s1_slot_reg;

endmodule

>>> hdl/psu_recon.sv
// Reconstruction stage: filter predictors, neighbor histories, output register.
// Depends on psu_pkg; reads line buffer data issued by psu_ctrl.
module psu_recon #(
    parameter int MAX_ROW_BYTES   = 16384,
    parameter int MAX_PIXEL_BYTES = 8,
    parameter int AW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1,
    parameter int SW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    input  psu_pkg::item_t item,
    input  logic [AW-1:0]  item_addr,
    input  logic [SW-1:0]  item_slot,
    input  logic [7:0]     rd_data,
    input  logic           hist_clear,
    output logic           take,
    output logic           wr_en,
    output logic [AW-1:0]  wr_addr,
    output logic [7:0]     wr_data,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [7:0]     out_byte,
    output logic           out_bad,
    output logic           out_row_last,
    output logic           out_image_last
);
    import psu_pkg::*;

    function automatic logic [7:0] paeth_pred(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c);
        logic signed [10:0] p, da, db, dc;
        logic        [10:0] pa, pb, pc;
        p  = $signed({3'b0, a}) + $signed({3'b0, b}) - $signed({3'b0, c});
        da = p - $signed({3'b0, a});
        db = p - $signed({3'b0, b});
        dc = p - $signed({3'b0, c});
        pa = (da < 0) ? 11'(-da) : 11'(da);
        pb = (db < 0) ? 11'(-db) : 11'(db);
        pc = (dc < 0) ? 11'(-dc) : 11'(dc);
        if (pa <= pb && pa <= pc)
        begin
            return a;
        end
        else if (pb <= pc)
        begin
            return b;
        end
        return c;
    endfunction

    logic [7:0] left_reg [MAX_PIXEL_BYTES];
    logic [7:0] ul_reg   [MAX_PIXEL_BYTES];

    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg;
    logic       out_bad_reg, out_rlast_reg, out_ilast_reg;

    logic [7:0] a, b, c, x;
    logic [8:0] avg_sum;

    assign take = item_valid && (!out_valid_reg || out_ready);

    assign a       = left_reg[item_slot];
    assign c       = ul_reg[item_slot];
    assign b       = item.first_row ? 8'd0 : rd_data;
    assign avg_sum = {1'b0, a} + {1'b0, b};

    always_comb
    begin
        unique case (item.filter)
            FILT_NONE:  x = item.data;
            FILT_SUB:   x = item.data + a;
            FILT_UP:    x = item.data + b;
            FILT_AVG:   x = item.data + avg_sum[8:1];
            FILT_PAETH: x = item.data + paeth_pred(a, b, c);
            default:    x = item.data;
        endcase
    end

    assign wr_en   = take && !item.bad;
    assign wr_addr = item_addr;
    assign wr_data = x;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_PIXEL_BYTES; i++)
            begin
                left_reg[i] <= '0;
                ul_reg[i]   <= '0;
            end
        end
        else if (hist_clear)
        begin
            for (int i = 0; i < MAX_PIXEL_BYTES; i++)
            begin
                left_reg[i] <= '0;
                ul_reg[i]   <= '0;
            end
        end
        else if (wr_en)
        begin
            left_reg[item_slot] <= x;
            ul_reg[item_slot]   <= b;
        end
    end

    assign out_valid_next = take || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_byte_reg  <= item.bad ? 8'd0 : x;
            out_bad_reg   <= item.bad;
            out_rlast_reg <= item.row_last;
            out_ilast_reg <= item.image_last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_byte       = out_byte_reg;
    assign out_bad        = out_bad_reg;
    assign out_row_last   = out_rlast_reg;
    assign out_image_last = out_ilast_reg;

endmodule

>>> hdl/png_scanline_unfilter.sv
// PNG scanline filter reconstruction: top level with configuration registers.
// Depends on psu_pkg, psu_ram, psu_ctrl, psu_recon and assert_macros.svh.
//
// Input stream (s_*): one filtered byte per beat; s_tuser marks an image start,
// which must be a filter byte. Each row is one filter byte then row_bytes data
// bytes. Filter bytes and dropped bytes produce no output beat.
// Output stream (m_*): one reconstructed byte per data beat; m_tlast flags the
// last byte of a row, m_tuser the error flag and the last byte of the image.
// A filter type above 4 gives one error beat, then input is dropped until the
// next image start; bytes after the last row are dropped likewise.
// Path: the input beat is registered with its line buffer read, then is
// reconstructed into the output register. Throughput: one byte per cycle
// when not stalled, set by the single read and single write port of the RAM.
// Stall: the output register holds; input stays ready while the stage behind
// it is empty, and backs up one beat after that.
// Reset: counters and histories clear, the block expects a filter byte and
// treats the next row as the first row; config resets to 1. The line buffer
// needs no clearing pass. Write config only while idle.
module png_scanline_unfilter #(
    parameter int MAX_ROW_BYTES   = 16384,
    parameter int MAX_PIXEL_BYTES = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] stream_byte
    input  logic [0:0]                     s_tuser,   // [0] image_start
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,   // [7:0] pixel_byte
    output logic                           m_tlast,
    output logic [1:0]                     m_tuser,   // [0] bad_filter, [1] image_last
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [psu_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [psu_pkg::CFG_DATA_W-1:0] cfg_data
);
    import psu_pkg::*;

    `include "assert_macros.svh"

    localparam int AW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
    localparam int SW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

    logic [BPP_W-1:0] bpp_reg;
    logic [RB_W-1:0]  rb_reg;
    logic [RC_W-1:0]  rc_reg;

    logic          take, item_valid, hist_clear, rd_en, wr_en;
    item_t         item;
    logic [AW-1:0] item_addr, rd_addr, wr_addr;
    logic [SW-1:0] item_slot;
    logic [7:0]    rd_data, wr_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_reg <= BPP_W'(1);
            rb_reg  <= RB_W'(1);
            rc_reg  <= RC_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_BPP:       bpp_reg <= cfg_data[BPP_W-1:0];
                REG_ROW_BYTES: rb_reg  <= cfg_data[RB_W-1:0];
                REG_ROW_COUNT: rc_reg  <= cfg_data[RC_W-1:0];
                default:       ;
            endcase
        end
    end

    psu_ctrl #(
        .MAX_ROW_BYTES   (MAX_ROW_BYTES),
        .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_bpp       (bpp_reg),
        .cfg_row_bytes (rb_reg),
        .cfg_row_count (rc_reg),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_byte       (s_tdata),
        .in_start      (s_tuser[0]),
        .take          (take),
        .item_valid    (item_valid),
        .item          (item),
        .item_addr     (item_addr),
        .item_slot     (item_slot),
        .hist_clear    (hist_clear),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr)
    );

    psu_ram #(
        .WIDTH (8),
        .DEPTH (MAX_ROW_BYTES)
    ) u_line_buf (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    psu_recon #(
        .MAX_ROW_BYTES   (MAX_ROW_BYTES),
        .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
    ) u_recon (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item           (item),
        .item_addr      (item_addr),
        .item_slot      (item_slot),
        .rd_data        (rd_data),
        .hist_clear     (hist_clear),
        .take           (take),
        .wr_en          (wr_en),
        .wr_addr        (wr_addr),
        .wr_data        (wr_data),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_byte       (m_tdata),
        .out_bad        (m_tuser[0]),
        .out_row_last   (m_tlast),
        .out_image_last (m_tuser[1])
    );

    `ASSERT_IMPL(a_stall_cause, !s_tready, m_tvalid && !m_tready, "stray input stall")
    `ASSERT_NEXT(a_write_beat, wr_en, m_tvalid, "write without output beat")
    `ASSERT_IMPL(a_err_zero, m_tvalid && m_tuser[0], m_tdata == 8'd0, "error beat data")
    `ASSERT_IMPL(a_err_last, m_tvalid && m_tuser[0], !m_tlast && !m_tuser[1], "err flags")
    `ASSERT_IMPL(a_ilast_row, m_tvalid && m_tuser[1], m_tlast, "image end off row end")

endmodule

>>> tb/png_scanline_unfilter_test.sv
// Self-checking testbench for png_scanline_unfilter: directed table, then random images.
// Holds its own line buffer and filter predictor; depends on psu_pkg and the RTL only.
module png_scanline_unfilter_test;
    import psu_pkg::*;

    localparam int LINE_MAX = 16384;
    localparam int PIX_MAX  = 8;

    typedef struct packed {
        logic [7:0] pixel;
        logic       bad;
        logic       row_end;
        logic       img_end;
    } pix_beat_t;

    typedef enum logic [1:0] {
        DIR_BEAT,
        DIR_KNOWN,
        DIR_CFG
    } dir_kind_t;

    typedef struct packed {
        dir_kind_t              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  val;
        logic                   start;
        pix_beat_t              exp;
    } dir_row_t;

    localparam pix_beat_t NO_PIX = '0;

    localparam dir_row_t DIRECTED [0:27] = '{
        '{DIR_BEAT,  REG_BPP,       16'(FILT_NONE),  1'b0, NO_PIX},
        '{DIR_KNOWN, REG_BPP,       16'h00FF,        1'b0, '{8'hFF, 1'b0, 1'b1, 1'b1}},
        '{DIR_BEAT,  REG_BPP,       16'h0000,        1'b0, NO_PIX},
        '{DIR_KNOWN, REG_BPP,       16'h0005,        1'b1, '{8'h00, 1'b1, 1'b0, 1'b0}},
        '{DIR_CFG,   REG_ROW_BYTES, 16'd2,           1'b0, NO_PIX},
        '{DIR_CFG,   REG_ROW_COUNT, 16'd3,           1'b0, NO_PIX},
        '{DIR_BEAT,  REG_BPP,       16'(FILT_NONE),  1'b1, NO_PIX},
        '{DIR_KNOWN, REG_BPP,       16'h0000,        1'b0, '{8'h00, 1'b0, 1'b0, 1'b0}},
        '{DIR_KNOWN, REG_BPP,       16'h00FF,        1'b0, '{8'hFF, 1'b0, 1'b1, 1'b0}},
        '{DIR_BEAT,  REG_BPP,       16'(FILT_UP),    1'b0, NO_PIX},
        '{DIR_BEAT,  REG_BPP,       16'h0001,        1'b0, NO_PIX},
        '{DIR_BEAT,  REG_BPP,       16'h00FF,        1'b0, NO_PIX},
        '{DIR_BEAT,  REG_BPP,       16'(FILT_PAETH), 1'b0, NO_PIX},
        '{DIR_BEAT,  REG_BPP,       16'h0080,        1'b0, NO_PIX},
        '{DIR_BEAT,  REG_BPP,       16'h0080,        1'b0, NO_PIX},
        '{DIR_BEAT,  REG_BPP,       16'(FILT_SUB),   1'b1, NO_PIX},
        '{DIR_BEAT,  REG_BPP,       16'h0010,        1'b0, NO_PIX},
        '{DIR_BEAT,  REG_BPP,       16'h00F0,        1'b0, NO_PIX},
        '{DIR_BEAT,  REG_BPP,       16'(FILT_AVG),   1'b0, NO_PIX},
        '{DIR_BEAT,  REG_BPP,       16'h00FF,        1'b0, NO_PIX},
        '{DIR_BEAT,  REG_BPP,       16'h0001,        1'b0, NO_PIX},
        '{DIR_KNOWN, REG_BPP,       16'h00FF,        1'b0, '{8'h00, 1'b1, 1'b0, 1'b0}},
        '{DIR_BEAT,  REG_BPP,       16'h0033,        1'b0, NO_PIX},
        '{DIR_BEAT,  REG_BPP,       16'(FILT_UP),    1'b1, NO_PIX},
        '{DIR_BEAT,  REG_BPP,       16'h0044,        1'b0, NO_PIX},
        '{DIR_BEAT,  REG_BPP,       16'(FILT_PAETH), 1'b1, NO_PIX},
        '{DIR_BEAT,  REG_BPP,       16'h007F,        1'b0, NO_PIX},
        '{DIR_BEAT,  REG_BPP,       16'h0080,        1'b0, NO_PIX}
    };

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata = '0;
    logic [0:0]             s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b1;
    logic [7:0]             m_tdata;
    logic                   m_tlast;
    logic [1:0]             m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    logic [BPP_W-1:0]       bpp_reg = 1;
    logic [RB_W-1:0]        row_len_reg = 1;
    logic [RC_W-1:0]        rows_reg = 1;

    logic [7:0]             line_buf [0:LINE_MAX-1];
    logic [7:0]             left_hist [0:PIX_MAX-1];
    logic [7:0]             diag_hist [0:PIX_MAX-1];
    filt_t                  cur_filter = FILT_NONE;
    int unsigned            col = 0;
    logic [15:0]            row_idx = '0;
    bit                     on_first_row = 1'b1;
    bit                     dropping = 1'b0;

    pix_beat_t              pending_pixels [$];
    int                     live_items = 0;
    int                     fail_cnt = 0;
    bit                     idling_on = 1'b1;
    int                     stall_left = 0;

    png_scanline_unfilter #(
        .MAX_ROW_BYTES   (LINE_MAX),
        .MAX_PIXEL_BYTES (PIX_MAX)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #20000000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic int unsigned eff_bpp();
        if (bpp_reg == 0)
            return 1;
        if (bpp_reg > PIX_MAX)
            return PIX_MAX;
        return bpp_reg;
    endfunction

    function automatic int unsigned eff_row_len();
        if (row_len_reg == 0)
            return 1;
        if (row_len_reg > LINE_MAX)
            return LINE_MAX;
        return row_len_reg;
    endfunction

    function automatic int unsigned eff_rows();
        return (rows_reg == 0) ? 1 : rows_reg;
    endfunction

    function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c);
        int p;
        int pa;
        int pb;
        int pc;
        p  = int'(a) + int'(b) - int'(c);
        pa = (p >= int'(a)) ? p - int'(a) : int'(a) - p;
        pb = (p >= int'(b)) ? p - int'(b) : int'(b) - p;
        pc = (p >= int'(c)) ? p - int'(c) : int'(c) - p;
        if (pa <= pb && pa <= pc)
            return a;
        if (pb <= pc)
            return b;
        return c;
    endfunction

    // Advance the predictor by one accepted byte; returns 1 unless the byte is dropped.
    function automatic bit unfilter_byte(input logic [7:0] sb, input bit st,
                                         output bit emits, output pix_beat_t res);
        int unsigned j;
        int unsigned slot;
        logic [7:0]  a;
        logic [7:0]  b;
        logic [7:0]  c;
        logic [7:0]  x;
        emits = 1'b0;
        res = '0;
        if (st)
        begin
            col = 0;
            row_idx = '0;
            on_first_row = 1'b1;
            dropping = 1'b0;
            left_hist = '{default: 8'h00};
            diag_hist = '{default: 8'h00};
        end
        else if (dropping)
            return 1'b0;

        if (col == 0)
        begin
            if (sb > FILT_MAX_CODE)
            begin
                dropping = 1'b1;
                emits = 1'b1;
                res.bad = 1'b1;
                return 1'b1;
            end
            cur_filter = filt_t'(sb[2:0]);
            left_hist = '{default: 8'h00};
            diag_hist = '{default: 8'h00};
            col = 1;
            return 1'b1;
        end

        j = col - 1;
        slot = (j % eff_bpp()) & (PIX_MAX - 1);
        a = left_hist[slot];
        c = diag_hist[slot];
        b = on_first_row ? 8'h00 : line_buf[j];
        unique case (cur_filter)
            FILT_SUB:   x = sb + a;
            FILT_UP:    x = sb + b;
            FILT_AVG:   x = sb + 8'(({1'b0, a} + {1'b0, b}) >> 1);
            FILT_PAETH: x = sb + paeth_pick(a, b, c);
            default:    x = sb;
        endcase
        left_hist[slot] = x;
        diag_hist[slot] = b;
        line_buf[j] = x;

        emits = 1'b1;
        res.pixel = x;
        if (j + 1 >= eff_row_len())
        begin
            res.row_end = 1'b1;
            res.img_end = (int'(row_idx) + 1 >= int'(eff_rows()));
            col = 0;
            on_first_row = 1'b0;
            row_idx = row_idx + 1'b1;
            if (res.img_end)
                dropping = 1'b1;
        end
        else
            col = col + 1;
        return 1'b1;
    endfunction

    task automatic send_beat(input logic [7:0] sb, input bit st, input bit typed,
                             input pix_beat_t typed_exp);
        pix_beat_t res;
        bit        emits;
        if (idling_on && $urandom_range(0, 7) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= sb;
        s_tuser <= st;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (unfilter_byte(sb, st, emits, res))
            live_items++;
        if (emits)
            pending_pixels.push_back(typed ? typed_exp : res);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        wait_drained();
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        unique case (idx)
            REG_BPP:       bpp_reg = val[BPP_W-1:0];
            REG_ROW_BYTES: row_len_reg = val[RB_W-1:0];
            REG_ROW_COUNT: rows_reg = val[RC_W-1:0];
            default:       ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 3)) send_beat(8'($urandom), 1'b0, 1'b0, NO_PIX);
    endtask

    function automatic logic [7:0] pick_byte();
        unique case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // One image, mostly well formed; else fewer rows, bad filter, cut row or trailing bytes.
    task automatic send_image(input bit clean);
        int         rows;
        int         len;
        logic [7:0] filt;
        rows = (eff_rows() > 6) ? $urandom_range(1, 6) : eff_rows();
        if (!clean && $urandom_range(0, 7) == 0)
            rows = $urandom_range(1, rows);
        for (int r = 0; r < rows; r++)
        begin
            if (!clean && $urandom_range(0, 15) == 0)
                filt = 8'($urandom_range(int'(FILT_MAX_CODE) + 1, 255));
            else
                filt = 8'(filt_t'($urandom_range(FILT_NONE, FILT_PAETH)));
            send_beat(filt, r == 0, 1'b0, NO_PIX);
            if (filt > FILT_MAX_CODE)
            begin
                send_noise();
                return;
            end
            len = eff_row_len();
            if (!clean && $urandom_range(0, 19) == 0)
                len = $urandom_range(0, len - 1);
            for (int k = 0; k < len; k++)
                send_beat(pick_byte(), 1'b0, 1'b0, NO_PIX);
            if (len < eff_row_len())
                return;
        end
        if (!clean && rows == eff_rows() && $urandom_range(0, 3) == 0)
            send_noise();
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                if (stall_left == 0)
                    m_tready <= 1'b1;
            end
            else if (idling_on && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 5);
                m_tready <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : check_beat
        pix_beat_t got;
        pix_beat_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '{m_tdata, m_tuser[0], m_tlast, m_tuser[1]};
            if (pending_pixels.size() == 0)
            begin
                fail_cnt++;
                if (fail_cnt <= 10)
                    $display("unexpected beat: pixel %02h bad %0d row_last %0d image_last %0d",
                             got.pixel, got.bad, got.row_end, got.img_end);
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (got.pixel !== want.pixel || got.bad !== want.bad ||
                    got.row_end !== want.row_end || got.img_end !== want.img_end)
                begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display({"mismatch: pixel %02h/%02h bad %0d/%0d row_last %0d/%0d",
                                  " image_last %0d/%0d (expected/actual)"},
                                 want.pixel, got.pixel, want.bad, got.bad,
                                 want.row_end, got.row_end, want.img_end, got.img_end);
                end
            end
        end
    end

    initial
    begin
        int base;
        left_hist = '{default: 8'h00};
        diag_hist = '{default: 8'h00};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
        begin
            if (DIRECTED[i].kind == DIR_CFG)
                write_reg(DIRECTED[i].idx, DIRECTED[i].val);
            else
                send_beat(DIRECTED[i].val[7:0], DIRECTED[i].start,
                          DIRECTED[i].kind == DIR_KNOWN, DIRECTED[i].exp);
        end

        for (int ph = 0; ph < 12; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(REG_BPP, 16'd1);
                    write_reg(REG_ROW_BYTES, 16'd1);
                    write_reg(REG_ROW_COUNT, 16'd1);
                end
                1:
                begin
                    write_reg(REG_BPP, 16'd8);
                    write_reg(REG_ROW_BYTES, 16'd16);
                    write_reg(REG_ROW_COUNT, 16'd4);
                end
                2:
                begin
                    write_reg(REG_BPP, 16'd0);
                    write_reg(REG_ROW_BYTES, 16'd0);
                    write_reg(REG_ROW_COUNT, 16'd0);
                end
                3:
                begin
                    write_reg(REG_BPP, 16'd15);
                    write_reg(REG_ROW_BYTES, 16'd20);
                    write_reg(REG_ROW_COUNT, 16'd3);
                end
                4:
                begin
                    write_reg(REG_BPP, 16'd3);
                    write_reg(REG_ROW_BYTES, 16'd7);
                    write_reg(REG_ROW_COUNT, 16'd65535);
                end
                5:
                begin
                    write_reg(REG_BPP, 16'd2);
                    write_reg(REG_ROW_BYTES, 16'd32767);
                    write_reg(REG_ROW_COUNT, 16'd1);
                end
                default:
                begin
                    write_reg(REG_BPP, 16'($urandom_range(1, PIX_MAX)));
                    write_reg(REG_ROW_BYTES, 16'($urandom_range(1, 24)));
                    write_reg(REG_ROW_COUNT, 16'($urandom_range(1, 6)));
                end
            endcase
            idling_on = (ph < 10);
            // open one over-long row and leave it unfinished
            if (ph == 5)
            begin
                send_beat(8'(FILT_SUB), 1'b1, 1'b0, NO_PIX);
                for (int k = 0; k < 40; k++)
                    send_beat(pick_byte(), 1'b0, 1'b0, NO_PIX);
            end
            else
            begin
                base = live_items;
                while (live_items - base < 160)
                    send_image(1'b0);
            end
        end

        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_cnt == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
